[src/arn_pkg.sv]
// ----------------------------------------------------------------------------
// arn_pkg
// Shared widths, constants, register indexes, transaction types and the
// log2 interpolation table of the auto range normalizer.
// ----------------------------------------------------------------------------
package arn_pkg;

   localparam int SW     = 32;               // sample width
   localparam int FB     = 16;               // fraction bits of a sample
   localparam int LTB    = 8;                // log table index bits
   localparam int LFRAC  = 16;               // fraction bits of a log2 value
   localparam int TAB_N  = 1 << LTB;
   localparam int QW     = SW + 1 + FB;      // quotient width of the divider
   localparam int QDEPTH = 2;                // front to back queue depth
   localparam int CSR_IDX_W = 3;

   localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] ONE  = SW'(1) << FB;

   // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for 0 <= x < 2^31
   localparam logic [31:0] RECIP_1000  = 32'd2199023256;
   localparam int          RECIP_SHIFT = 41;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOG_EN      = 3'd0,
      CSR_SYM         = 3'd1,
      CSR_AUTO        = 3'd2,
      CSR_PRESET_EN   = 3'd3,
      CSR_PRESET_LOW  = 3'd4,
      CSR_PRESET_HIGH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SW-1:0] sample;
      logic                 clamp;
      logic signed [SW-1:0] lo;
      logic signed [SW-1:0] hi;
      logic                 valid;
      logic                 log_act;
   } item_type;

   typedef struct packed {
      logic signed [SW-1:0] norm;
      logic signed [SW-1:0] lo;
      logic signed [SW-1:0] hi;
      logic                 log_act;
      logic                 degen;
   } result_type;

   typedef logic [LFRAC:0] log_tab_type [0:TAB_N];

   // log2(1 + i/TAB_N) by repeated squaring of a 30-bit mantissa
   function automatic log_tab_type build_log_tab();
      log_tab_type      tab;
      logic [63:0]      m;
      logic [LFRAC-1:0] f;
      for (int i = 0; i < TAB_N; i++) begin
         m = 64'(TAB_N + i) << (30 - LTB);
         f = '0;
         for (int k = 0; k < LFRAC; k++) begin
            m = (m * m) >> 30;
            f = {f[LFRAC-2:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
               f[0] = 1'b1;
               m = m >> 1;
            end
         end
         tab[i] = {1'b0, f};
      end
      tab[TAB_N] = (LFRAC+1)'(1) << LFRAC;
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

endpackage

[src/arn_queue.sv]
// ----------------------------------------------------------------------------
// arn_queue
// Short queue of classified samples between the range tracker and the
// normalizing back end.
// ----------------------------------------------------------------------------
module arn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  arn_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output arn_pkg::item_type head_item,
   output logic              empty
);

   localparam int PW = $clog2(arn_pkg::QDEPTH);

   arn_pkg::item_type   mem_ff [arn_pkg::QDEPTH];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       rd_ptr_ff;
   logic [PW:0]         count_ff;

   assign full      = (count_ff == (PW+1)'(arn_pkg::QDEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
      end
   end

endmodule

[src/arn_front.sv]
// ----------------------------------------------------------------------------
// arn_front
// Configuration registers and range tracking: widens or re-centers the
// range with each sample and hands the classified sample to the queue.
// ----------------------------------------------------------------------------
module arn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic signed [arn_pkg::SW-1:0] req_sample,
   input  logic                          req_clamp_output,
   output logic                          req_full,
   input  logic                          csr_we,
   input  logic [arn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [arn_pkg::SW-1:0]        csr_wdata,
   input  logic                          q_full,
   output logic                          q_push,
   output arn_pkg::item_type             q_item
);

   localparam int SW = arn_pkg::SW;

   logic                 log_en_ff, sym_ff, preset_en_ff;
   logic signed [SW-1:0] preset_low_ff, preset_high_ff;
   logic signed [SW-1:0] range_low_ff, range_high_ff;
   logic                 range_valid_ff, log_active_ff, auto_active_ff;

   logic                 stg_busy_ff;
   arn_pkg::item_type    stg_item_ff;
   logic                 stg_fix_ff;

   logic                 accept;
   logic signed [SW-1:0] wd;
   arn_pkg::item_type    stage_a;
   logic                 fix_a;
   logic [63:0]          div_prod;
   logic [63-arn_pkg::RECIP_SHIFT:0] low_m;
   logic signed [SW-1:0] lo_b;

   function automatic logic signed [SW-1:0] sat_abs(input logic signed [SW-1:0] x);
      if (x >= 0) return x;
      if (x == arn_pkg::SMIN) return arn_pkg::SMAX;
      return -x;
   endfunction

   assign req_full = stg_busy_ff | q_full;
   assign accept   = req_push & ~req_full;
   assign wd       = signed'(csr_wdata);

   // range update up to the forced-positive max
   always_comb begin
      logic                 sym, la;
      logic signed [SW-1:0] v, lo, hi, av, al, ah, big, ah2;
      v   = req_sample;
      sym = sym_ff & ~log_en_ff;
      la  = log_active_ff & ~v[SW-1];
      lo  = range_low_ff;
      hi  = range_high_ff;
      av  = sat_abs(v);
      al  = sat_abs(range_low_ff);
      ah  = sat_abs(range_high_ff);
      big = (al > ah) ? al : ah;
      if (sym) begin
         if (av > big || !range_valid_ff) begin
            lo = -av;
            hi = av;
         end
      end else begin
         if (v < lo) begin
            if (v == 0 && la) lo = (range_high_ff > 0) ? SW'(1) : SW'(0);
            else lo = v;
         end
         if (v > hi) hi = v;
      end
      if (lo > hi) lo = hi;
      ah2 = sat_abs(hi);
      if (la && hi <= 0) hi = (ah2 > 0) ? ah2 : arn_pkg::ONE;
      stage_a.sample = v;
      stage_a.clamp  = req_clamp_output;
      if (auto_active_ff) begin
         stage_a.lo      = lo;
         stage_a.hi      = hi;
         stage_a.valid   = 1'b1;
         stage_a.log_act = la;
         fix_a           = la;
      end else begin
         stage_a.lo      = range_low_ff;
         stage_a.hi      = range_high_ff;
         stage_a.valid   = range_valid_ff;
         stage_a.log_act = log_active_ff;
         fix_a           = 1'b0;
      end
   end

   // registered stage: min becomes max/1000 when it is unusable in log mode
   assign div_prod = $unsigned(stg_item_ff.hi) * arn_pkg::RECIP_1000;
   assign low_m    = div_prod[63:arn_pkg::RECIP_SHIFT];

   always_comb begin
      lo_b = stg_item_ff.lo;
      if (stg_fix_ff && (stg_item_ff.lo <= 0 || stg_item_ff.lo >= stg_item_ff.hi)) begin
         lo_b = (low_m != '0) ? SW'(low_m) : SW'(1);
      end
   end

   always_comb begin
      q_item    = stg_item_ff;
      q_item.lo = lo_b;
   end
   assign q_push = stg_busy_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_item_ff <= stage_a;
         stg_fix_ff  <= fix_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_en_ff      <= 1'b0;
         sym_ff         <= 1'b0;
         preset_en_ff   <= 1'b0;
         preset_low_ff  <= '0;
         preset_high_ff <= arn_pkg::ONE;
         range_low_ff   <= arn_pkg::SMAX;
         range_high_ff  <= arn_pkg::SMIN;
         range_valid_ff <= 1'b0;
         log_active_ff  <= 1'b0;
         auto_active_ff <= 1'b1;
         stg_busy_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               arn_pkg::CSR_LOG_EN: begin
                  log_en_ff     <= csr_wdata[0];
                  log_active_ff <= csr_wdata[0];
               end
               arn_pkg::CSR_SYM: sym_ff <= csr_wdata[0];
               arn_pkg::CSR_AUTO: auto_active_ff <= csr_wdata[0];
               arn_pkg::CSR_PRESET_EN: begin
                  preset_en_ff <= csr_wdata[0];
                  if (csr_wdata[0]) begin
                     range_low_ff   <= preset_low_ff;
                     range_high_ff  <= preset_high_ff;
                     range_valid_ff <= preset_low_ff <= preset_high_ff;
                     if (preset_low_ff <= preset_high_ff) auto_active_ff <= 1'b0;
                  end
               end
               arn_pkg::CSR_PRESET_LOW: begin
                  preset_low_ff <= wd;
                  if (preset_en_ff) begin
                     range_low_ff   <= wd;
                     range_high_ff  <= preset_high_ff;
                     range_valid_ff <= wd <= preset_high_ff;
                     if (wd <= preset_high_ff) auto_active_ff <= 1'b0;
                  end
               end
               arn_pkg::CSR_PRESET_HIGH: begin
                  preset_high_ff <= wd;
                  if (preset_en_ff) begin
                     range_low_ff   <= preset_low_ff;
                     range_high_ff  <= wd;
                     range_valid_ff <= preset_low_ff <= wd;
                     if (preset_low_ff <= wd) auto_active_ff <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
         if (accept) begin
            stg_busy_ff <= 1'b1;
         end
         if (stg_busy_ff) begin
            range_low_ff   <= lo_b;
            range_high_ff  <= stg_item_ff.hi;
            range_valid_ff <= stg_item_ff.valid;
            log_active_ff  <= stg_item_ff.log_act;
            stg_busy_ff    <= 1'b0;
         end
      end
   end

endmodule

[src/arn_log2.sv]
// ----------------------------------------------------------------------------
// arn_log2
// Fixed-point log2 of a positive sample: shifts to the leading one a bit
// per cycle, then interpolates the table.
// ----------------------------------------------------------------------------
module arn_log2 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [arn_pkg::SW-1:0]        x,
   output logic                          done,
   output logic signed [arn_pkg::SW-1:0] result
);

   localparam int SW    = arn_pkg::SW;
   localparam int PW    = $clog2(SW);
   localparam int LTB   = arn_pkg::LTB;
   localparam int LFRAC = arn_pkg::LFRAC;

   logic [SW-1:0]        x_ff;
   logic [PW-1:0]        p_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic signed [SW-1:0] result_ff;

   logic [LFRAC-1:0]     t;
   logic [LTB-1:0]       idx;
   logic [LTB:0]         idx_next;
   logic [LFRAC-LTB-1:0] rem;
   logic [LFRAC:0]       ta, tb, frac;
   logic [LFRAC+LTB:0]   interp;
   logic signed [PW+1:0] ip;
   logic signed [SW-1:0] res;

   // bits below the leading one once it sits at the top
   assign t        = x_ff[SW-2 -: LFRAC];
   assign idx      = t[LFRAC-1 -: LTB];
   assign idx_next = {1'b0, idx} + (LTB+1)'(1);
   assign rem      = t[LFRAC-LTB-1:0];
   assign ta       = arn_pkg::LOG_TAB[idx];
   assign tb       = arn_pkg::LOG_TAB[idx_next];
   assign interp   = (LFRAC+LTB+1)'(tb - ta) * (LFRAC+LTB+1)'(rem);
   assign frac     = ta + (LFRAC+1)'(interp >> (LFRAC - LTB));
   assign ip       = $signed({2'b00, p_ff}) - (PW+2)'(arn_pkg::FB);
   assign res      = (SW'(ip) <<< LFRAC) + SW'(frac);

   assign done   = done_ff;
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x;
         p_ff <= PW'(SW - 1);
      end else if (busy_ff && !x_ff[SW-1]) begin
         x_ff <= x_ff << 1;
         p_ff <= p_ff - PW'(1);
      end
      if (busy_ff && x_ff[SW-1]) begin
         result_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && x_ff[SW-1]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

endmodule

[src/arn_div.sv]
// ----------------------------------------------------------------------------
// arn_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^FB / den).
// ----------------------------------------------------------------------------
module arn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [arn_pkg::SW:0]        num,
   input  logic [arn_pkg::SW-1:0]      den,
   output logic                        done,
   output logic [arn_pkg::QW-1:0]      quot
);

   localparam int SW = arn_pkg::SW;
   localparam int QW = arn_pkg::QW;
   localparam int CW = $clog2(QW + 1);

   logic [SW-1:0] rem_ff;
   logic [SW-1:0] den_ff;
   logic [QW-1:0] dvd_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [SW:0]   trial;
   logic          ge;
   logic [SW:0]   diff;

   assign trial = {rem_ff, dvd_ff[QW-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};
   assign done  = done_ff;
   assign quot  = dvd_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         dvd_ff <= {num, {arn_pkg::FB{1'b0}}};
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[SW-1:0] : trial[SW-1:0];
         dvd_ff <= {dvd_ff[QW-2:0], ge};
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(QW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

endmodule

[src/arn_back.sv]
// ----------------------------------------------------------------------------
// arn_back
// Normalizing back end: log2 of the bounds and the sample, the position
// ratio on the shared divider, saturation, clamping and the result register.
// ----------------------------------------------------------------------------
module arn_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  arn_pkg::item_type   q_item,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output arn_pkg::result_type rsp_result
);

   localparam int SW = arn_pkg::SW;
   localparam int QW = arn_pkg::QW;

   typedef enum logic [8:0] {
      B_IDLE = 9'b000000001,
      B_LIN  = 9'b000000010,
      B_LLO  = 9'b000000100,
      B_LHI  = 9'b000001000,
      B_LCHK = 9'b000010000,
      B_LV   = 9'b000100000,
      B_DSET = 9'b001000000,
      B_DIV  = 9'b010000000,
      B_DONE = 9'b100000000
   } back_state_type;

   back_state_type       state_ff;
   logic                 issued_ff;
   arn_pkg::item_type    item_ff;
   logic signed [SW-1:0] ll_ff, lh_ff;
   logic signed [SW-1:0] opv_ff, oplo_ff, ophi_ff;
   logic [SW:0]          num_ff;
   logic [SW-1:0]        den_ff;
   logic                 neg_ff;
   logic signed [SW-1:0] n_ff;
   logic                 degen_ff;
   logic                 out_valid_ff;
   arn_pkg::result_type  out_ff;

   logic                 in_log;
   logic signed [SW-1:0] lg_x;
   logic                 lg_pos;
   logic                 lg_start, lg_done;
   logic signed [SW-1:0] lg_result;
   logic signed [SW-1:0] lg_value;
   logic                 div_start, div_done;
   logic [QW-1:0]        quot;
   logic signed [SW:0]   dv, dh;
   logic signed [SW-1:0] n_sat;

   assign in_log = (state_ff == B_LLO) || (state_ff == B_LHI) || (state_ff == B_LV);

   always_comb begin
      unique case (state_ff)
         B_LLO:   lg_x = item_ff.lo;
         B_LHI:   lg_x = item_ff.hi;
         default: lg_x = item_ff.sample;
      endcase
   end

   assign lg_pos    = lg_x > 0;
   assign lg_start  = in_log && !issued_ff && lg_pos;
   // a bound or sample that is not positive takes log value 0
   assign lg_value  = issued_ff ? lg_result : '0;
   assign div_start = (state_ff == B_DIV) && !issued_ff;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_result = out_ff;

   assign dv = {opv_ff[SW-1], opv_ff} - {oplo_ff[SW-1], oplo_ff};
   assign dh = {ophi_ff[SW-1], ophi_ff} - {oplo_ff[SW-1], oplo_ff};

   // saturate the quotient, apply sign and clamp
   always_comb begin
      if (neg_ff) begin
         if (quot >= (QW'(1) << (SW - 1))) n_sat = arn_pkg::SMIN;
         else n_sat = -signed'(quot[SW-1:0]);
      end else begin
         if (quot > QW'(arn_pkg::SMAX)) n_sat = arn_pkg::SMAX;
         else n_sat = signed'(quot[SW-1:0]);
      end
      if (item_ff.log_act || item_ff.clamp) begin
         if (n_sat < 0) n_sat = '0;
         if (n_sat > arn_pkg::ONE) n_sat = arn_pkg::ONE;
      end
   end

   arn_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (lg_start),
      .x      (lg_x),
      .done   (lg_done),
      .result (lg_result)
   );

   arn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // payload registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            item_ff <= q_item;
            opv_ff  <= q_item.sample;
            oplo_ff <= q_item.lo;
            ophi_ff <= q_item.hi;
         end
         B_LIN: begin
            n_ff     <= '0;
            degen_ff <= !item_ff.valid || item_ff.hi <= item_ff.lo;
         end
         B_LLO: if (!issued_ff ? !lg_pos : lg_done) ll_ff <= lg_value;
         B_LHI: if (!issued_ff ? !lg_pos : lg_done) lh_ff <= lg_value;
         B_LCHK: begin
            degen_ff <= !item_ff.valid || lh_ff <= ll_ff;
            n_ff     <= (item_ff.sample >= item_ff.hi && item_ff.sample > item_ff.lo
                         && item_ff.valid && lh_ff > ll_ff) ? arn_pkg::ONE : '0;
         end
         B_LV: begin
            if (!issued_ff ? !lg_pos : lg_done) begin
               opv_ff  <= lg_value;
               oplo_ff <= ll_ff;
               ophi_ff <= lh_ff;
            end
         end
         B_DSET: begin
            neg_ff <= dv < 0;
            num_ff <= (dv < 0) ? unsigned'(-dv) : unsigned'(dv);
            den_ff <= dh[SW-1:0];
         end
         B_DIV: if (issued_ff && div_done) n_ff <= n_sat;
         B_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_ff.norm    <= n_ff;
               out_ff.lo      <= item_ff.lo;
               out_ff.hi      <= item_ff.hi;
               out_ff.log_act <= item_ff.log_act;
               out_ff.degen   <= degen_ff;
            end
         end
         default: ;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         issued_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff && state_ff != B_DONE) out_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               issued_ff <= 1'b0;
               if (!q_empty) state_ff <= q_item.log_act ? B_LLO : B_LIN;
            end
            B_LIN: begin
               if (!item_ff.valid || item_ff.hi <= item_ff.lo) state_ff <= B_DONE;
               else state_ff <= B_DSET;
            end
            B_LLO, B_LHI, B_LV: begin
               if (!issued_ff && lg_pos) begin
                  issued_ff <= 1'b1;
               end else if (!issued_ff || lg_done) begin
                  issued_ff <= 1'b0;
                  unique case (state_ff)
                     B_LLO:   state_ff <= B_LHI;
                     B_LHI:   state_ff <= B_LCHK;
                     default: state_ff <= B_DSET;
                  endcase
               end
            end
            B_LCHK: begin
               if (!item_ff.valid || lh_ff <= ll_ff) state_ff <= B_DONE;
               else if (item_ff.sample <= item_ff.lo) state_ff <= B_DONE;
               else if (item_ff.sample >= item_ff.hi) state_ff <= B_DONE;
               else state_ff <= B_LV;
            end
            B_DSET: begin
               issued_ff <= 1'b0;
               state_ff  <= B_DIV;
            end
            B_DIV: begin
               if (!issued_ff) issued_ff <= 1'b1;
               else if (div_done) state_ff <= B_DONE;
            end
            B_DONE: begin
               // a pop in the same cycle frees the register for the new result
               if (!out_valid_ff || rsp_pop) begin
                  out_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

[src/auto_range_normalizer.sv]
// ----------------------------------------------------------------------------
// auto_range_normalizer
// Tracks a min/max range over a stream of signed Q16.16 samples and returns
// each sample's position in that range, linear or on a log2 scale.
// ----------------------------------------------------------------------------
// The front end does the range compare, then the divide-by-1000 multiply,
// takes no new sample while its staging register holds one, and queues up to
// two of them. The back end normalizes one sample at a time: a linear sample
// runs through the bit-serial divider (49 quotient bits); a log-mode sample
// adds up to three log2 evaluations, each paced by the bit-per-cycle
// leading-one shift. Results wait in an output register, so the back end
// starts the next sample once the previous result has been taken or the
// register is free.
module auto_range_normalizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [arn_pkg::SW-1:0] req_sample,
   input  logic                          req_clamp_output,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [arn_pkg::SW-1:0] rsp_norm_value,
   output logic signed [arn_pkg::SW-1:0] rsp_range_low_out,
   output logic signed [arn_pkg::SW-1:0] rsp_range_high_out,
   output logic                          rsp_log_active_out,
   output logic                          rsp_degenerate,
   input  logic                          csr_we,
   input  logic [arn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [arn_pkg::SW-1:0]        csr_wdata
);

   logic                q_push, q_full, q_pop, q_empty;
   arn_pkg::item_type   push_item, head_item;
   arn_pkg::result_type result;

   arn_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_sample       (req_sample),
      .req_clamp_output (req_clamp_output),
      .req_full         (req_full),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   arn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty)
   );

   arn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_result (result)
   );

   assign rsp_norm_value     = result.norm;
   assign rsp_range_low_out  = result.lo;
   assign rsp_range_high_out = result.hi;
   assign rsp_log_active_out = result.log_act;
   assign rsp_degenerate     = result.degen;

endmodule

[src/arn_checker.sv]
// ----------------------------------------------------------------------------
// arn_checker
// Port-level checks of the auto range normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module arn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic signed [arn_pkg::SW-1:0] rsp_norm_value,
   input logic signed [arn_pkg::SW-1:0] rsp_range_low_out,
   input logic signed [arn_pkg::SW-1:0] rsp_range_high_out,
   input logic                          rsp_log_active_out,
   input logic                          rsp_degenerate
);

   // no result and room for a transaction right after reset
   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty or full after reset");

   // a degenerate range always yields zero
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_degenerate |-> rsp_norm_value == 0)
      else $error("degenerate result is not zero");

   // log scale results lie within 0..1
   a_log_bounded: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_log_active_out |->
         rsp_norm_value >= 0 && rsp_norm_value <= arn_pkg::ONE)
      else $error("log result outside 0..1");

   // a result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_norm_value)
         && $stable(rsp_range_low_out) && $stable(rsp_range_high_out))
      else $error("waiting result changed");

endmodule

bind auto_range_normalizer arn_checker u_arn_checker (.*);

[test/auto_range_normalizer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_range_normalizer_checker
// Watches the sample, result and register ports of the normalizer, predicts
// every result from its own model of the range tracker and compares field
// by field in order of arrival.
// ----------------------------------------------------------------------------
module auto_range_normalizer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  logic signed [arn_pkg::SW-1:0] req_sample,
   input  logic                          req_clamp_output,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  logic signed [arn_pkg::SW-1:0] rsp_norm_value,
   input  logic signed [arn_pkg::SW-1:0] rsp_range_low_out,
   input  logic signed [arn_pkg::SW-1:0] rsp_range_high_out,
   input  logic                          rsp_log_active_out,
   input  logic                          rsp_degenerate,
   input  logic                          csr_we,
   input  logic [arn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [arn_pkg::SW-1:0]        csr_wdata,
   output int                            mismatches,
   output int                            outstanding
);
   import arn_pkg::*;

   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;
   localparam longint UNIT = 64'sd65536;

   result_type norm_queue[$];
   longint     log2_tab[0:TAB_N];

   // register copies
   bit     log_en, sym_en, auto_en, preset_en;
   longint preset_lo, preset_hi;
   // tracked state
   longint lo, hi, log_lo, log_hi;
   bit     span_valid, log_on, auto_on;

   function automatic void fill_log2_tab();
      logic [63:0] m;
      longint      f;
      for (int i = 0; i < TAB_N; i++) begin
         m = 64'(TAB_N + i) << (30 - LTB);
         f = 0;
         for (int k = 0; k < LFRAC; k++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31)) begin
               f = f | 1;
               m = m >> 1;
            end
         end
         log2_tab[i] = f;
      end
      log2_tab[TAB_N] = 64'sd1 << LFRAC;
   endfunction

   function automatic longint fix_log2(logic [63:0] x);
      int          p;
      logic [63:0] t;
      longint      idx, rem, a, b;
      p = 63;
      while (p > 0 && !x[p]) p--;
      if (p >= LFRAC) t = (x >> (p - LFRAC)) & 64'hFFFF;
      else t = (x << (LFRAC - p)) & 64'hFFFF;
      idx = longint'(t >> (LFRAC - LTB));
      rem = longint'(t & ((64'd1 << (LFRAC - LTB)) - 1));
      a = log2_tab[idx];
      b = log2_tab[idx + 1];
      return longint'(p - FB) * (64'sd1 << LFRAC) + a + (((b - a) * rem) >>> (LFRAC - LTB));
   endfunction

   function automatic void refresh_logs();
      log_lo = lo > 0 ? fix_log2(lo) : 0;
      log_hi = hi > 0 ? fix_log2(hi) : 0;
   endfunction

   function automatic longint mag(longint v);
      if (v >= 0) return v;
      if (v == MINV) return MAXV;
      return -v;
   endfunction

   // a * 2^FB / b truncated, saturated to lim
   function automatic logic [63:0] frac_div(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
      logic [63:0] q, r;
      logic        carry;
      q = a / b;
      r = a % b;
      if (q > (lim >> FB)) return lim;
      for (int k = 0; k < FB; k++) begin
         carry = r[63];
         r = r << 1;
         q = q << 1;
         if (carry || r >= b) begin
            r = r - b;
            q[0] = 1'b1;
         end
      end
      return q > lim ? lim : q;
   endfunction

   function automatic longint position(longint v, longint l, longint h);
      logic [63:0] den, m;
      den = 64'(h) - 64'(l);
      if (v >= l) return longint'(frac_div(64'(v) - 64'(l), den, 64'(MAXV)));
      m = frac_div(64'(l) - 64'(v), den, 64'(MAXV) + 64'd1);
      if (m == 64'(MAXV) + 64'd1) return MINV;
      return -longint'(m);
   endfunction

   function automatic void take_preset();
      lo = preset_lo;
      hi = preset_hi;
      span_valid = preset_lo <= preset_hi;
      if (span_valid) auto_on = 0;
   endfunction

   function automatic void widen_range(longint v);
      longint av, big, m;
      if (log_on && v < 0) log_on = 0;
      if (sym_en && !log_en) begin
         av = mag(v);
         big = mag(lo) > mag(hi) ? mag(lo) : mag(hi);
         if (av > big || !span_valid) begin
            lo = -av;
            hi = av;
         end
      end else begin
         if (v < lo) begin
            // zero below the range cannot be a log bound
            if (v == 0 && log_on) lo = hi > 0 ? 1 : 0;
            else lo = v;
         end
         if (v > hi) hi = v;
      end
      if (lo > hi) lo = hi;
      if (log_on) begin
         if (hi <= 0) hi = mag(hi) > 0 ? mag(hi) : UNIT;
         if (lo <= 0 || lo >= hi) begin
            m = hi / 1000;
            lo = m > 0 ? m : 1;
         end
         refresh_logs();
      end
      span_valid = 1;
   endfunction

   function automatic result_type normalize(longint v, bit clamp);
      result_type r;
      longint     n;
      bit         degen;
      n = 0;
      if (auto_on) widen_range(v);
      if (!log_on) begin
         degen = !span_valid || hi <= lo;
         if (!degen) begin
            n = position(v, lo, hi);
            if (clamp) begin
               if (n < 0) n = 0;
               if (n > UNIT) n = UNIT;
            end
         end
      end else begin
         degen = !span_valid || log_hi <= log_lo;
         if (!degen) begin
            if (v <= lo) n = 0;
            else if (v >= hi) n = UNIT;
            else begin
               n = position(v > 0 ? fix_log2(v) : 0, log_lo, log_hi);
               if (n < 0) n = 0;
               if (n > UNIT) n = UNIT;
            end
         end
      end
      r.norm = n[SW-1:0];
      r.lo = lo[SW-1:0];
      r.hi = hi[SW-1:0];
      r.log_act = log_on;
      r.degen = degen;
      return r;
   endfunction

   function automatic void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SW-1:0] data);
      case (csr_index_type'(idx))
         CSR_LOG_EN: begin
            log_en = data[0];
            log_on = data[0];
         end
         CSR_SYM: sym_en = data[0];
         CSR_AUTO: begin
            auto_en = data[0];
            auto_on = data[0];
         end
         CSR_PRESET_EN: begin
            preset_en = data[0];
            if (preset_en) take_preset();
         end
         CSR_PRESET_LOW: begin
            preset_lo = longint'($signed(data));
            if (preset_en) take_preset();
         end
         CSR_PRESET_HIGH: begin
            preset_hi = longint'($signed(data));
            if (preset_en) take_preset();
         end
         default: return;
      endcase
      refresh_logs();
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch %0t: %s got %0d expected %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   initial mismatches = 0;
   assign outstanding = norm_queue.size();

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fill_log2_tab();
         norm_queue.delete();
         log_en = 0; sym_en = 0; auto_en = 1; preset_en = 0;
         preset_lo = 0; preset_hi = UNIT;
         lo = MAXV; hi = MINV;
         span_valid = 0; log_on = 0; auto_on = 1;
         log_lo = 0; log_hi = 0;
      end else begin
         if (csr_we) write_reg(csr_index, csr_wdata);
         if (req_push && !req_full)
            norm_queue.push_back(normalize(longint'(req_sample), req_clamp_output));
         if (rsp_pop && !rsp_empty) begin
            if (norm_queue.size() == 0) begin
               $display("mismatch %0t: result transaction with none expected", $realtime);
               mismatches++;
            end else begin
               want = norm_queue.pop_front();
               if (rsp_norm_value !== want.norm)
                  report("norm_value", rsp_norm_value, want.norm);
               if (rsp_range_low_out !== want.lo)
                  report("range_low_out", rsp_range_low_out, want.lo);
               if (rsp_range_high_out !== want.hi)
                  report("range_high_out", rsp_range_high_out, want.hi);
               if (rsp_log_active_out !== want.log_act)
                  report("log_active_out", rsp_log_active_out, want.log_act);
               if (rsp_degenerate !== want.degen)
                  report("degenerate", rsp_degenerate, want.degen);
            end
         end
      end
   end

endmodule

[test/auto_range_normalizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_range_normalizer_tb
// Drives directed and random sample streams through the normalizer under a
// series of register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module auto_range_normalizer_tb;
   import arn_pkg::*;

   localparam int LIMIT  = 1500000;
   localparam int SETTLE = 200;        // worst back end latency plus margin

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_push = 0;
   logic                          req_full;
   logic signed [SW-1:0]          req_sample = '0;
   logic                          req_clamp_output = 0;
   logic                          rsp_empty;
   logic                          rsp_pop = 0;
   logic signed [SW-1:0]          rsp_norm_value;
   logic signed [SW-1:0]          rsp_range_low_out;
   logic signed [SW-1:0]          rsp_range_high_out;
   logic                          rsp_log_active_out;
   logic                          rsp_degenerate;
   logic                          csr_we = 0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [SW-1:0]                 csr_wdata = '0;
   int                            mismatches;
   int                            outstanding;
   int                            cycles = 0;
   int                            burst_left = 0;
   logic                          hold_off = 0;
   int                            pop_rate = 100;
   int                            rate_timer = 0;

   auto_range_normalizer dut (.*);

   auto_range_normalizer_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: changing pop rate, plus one long hold-off
   always @(posedge clock) begin
      if (rate_timer == 0) begin
         case ($urandom_range(0, 3))
            0: pop_rate <= 100;
            1: pop_rate <= 70;
            2: pop_rate <= 30;
            default: pop_rate <= 5;
         endcase
         rate_timer <= $urandom_range(50, 600);
      end else begin
         rate_timer <= rate_timer - 1;
      end
      rsp_pop <= !hold_off && ($urandom_range(0, 99) < pop_rate);
   end

   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      hold_off <= 1;
      repeat (700) @(posedge clock);
      hold_off <= 0;
   end

   task automatic push_sample(logic signed [SW-1:0] s, logic c);
      bit stalled;
      int gap;
      req_sample <= s;
      req_clamp_output <= c;
      req_push <= 1;
      do begin
         @(negedge clock);
         stalled = req_full;
         @(posedge clock);
      end while (stalled);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_push <= 0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // all six registers, preset enable last so it decides the range
   task automatic write_regs(bit lg, bit sy, bit au, bit pe, logic [SW-1:0] plo,
                             logic [SW-1:0] phi);
      logic [SW-1:0] vals [6];
      csr_index_type order [6];
      vals = '{SW'(lg), SW'(sy), plo, phi, SW'(au), SW'(pe)};
      order = '{CSR_LOG_EN, CSR_SYM, CSR_PRESET_LOW, CSR_PRESET_HIGH, CSR_AUTO,
                CSR_PRESET_EN};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic signed [SW-1:0] pick_sample(bit positive);
      logic signed [SW-1:0] s;
      case ($urandom_range(0, 9))
         0, 1: s = $urandom;
         2: case ($urandom_range(0, 5))
               0: s = SMIN;
               1: s = SMAX;
               2: s = 0;
               3: s = -1;
               4: s = 1;
               default: s = ONE;
            endcase
         3, 4, 5: s = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: s = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      endcase
      if (positive && $urandom_range(0, 19) != 0 && s < 0) s = (s == SMIN) ? SMAX : -s;
      return s;
   endfunction

   task automatic random_phase(bit lg, bit sy, bit au, bit pe, logic [SW-1:0] plo,
                               logic [SW-1:0] phi, int n);
      write_regs(lg, sy, au, pe, plo, phi);
      for (int i = 0; i < n; i++) push_sample(pick_sample(lg), $urandom_range(0, 1));
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: empty range, then extremes widen it
      push_sample(SMIN, 0);
      push_sample(0, 0);
      push_sample(SMAX, 0);
      push_sample(-1, 1);
      push_sample(1, 0);
      push_sample(ONE, 1);
      push_sample(SMIN, 1);
      drain();

      // log scale over a preset two-decade range, out-of-range ends included
      write_regs(1, 0, 1, 1, ONE, 100 * ONE);
      push_sample(0, 0);
      push_sample(ONE, 0);
      push_sample(ONE / 2, 1);
      push_sample(10 * ONE, 0);
      push_sample(100 * ONE, 0);
      push_sample(200 * ONE, 1);
      push_sample(-5, 0);
      drain();

      // log scale tracking: zero below the range, then a negative turns it off
      write_regs(1, 1, 1, 0, SMAX, SMIN);
      push_sample(3 * ONE, 0);
      push_sample(0, 0);
      push_sample(ONE, 0);
      push_sample(5, 0);
      push_sample(-7 * ONE, 1);
      push_sample(2 * ONE, 0);
      drain();

      random_phase(0, 0, 1, 1, SMAX, SMIN, 110);
      random_phase(0, 1, 1, 0, 0, ONE, 110);
      random_phase(1, 0, 1, 1, ONE, 1000 * ONE, 110);
      random_phase(1, 0, 1, 0, 0, 0, 110);
      random_phase(0, 0, 0, 1, 5 * ONE, -ONE, 100);        // invalid preset
      random_phase(0, 0, 1, 1, SMIN, SMAX, 110);
      random_phase(0, 0, 1, 1, 5, 5, 100);                 // zero width
      random_phase(1, 1, 1, 1, SMAX, SMIN, 110);
      random_phase(0, 0, 0, 0, 0, 0, 100);                 // frozen range
      random_phase(0, 1, 1, 1, -ONE, ONE, 110);
      random_phase(1, 0, 1, 1, 1, 2, 110);
      random_phase(0, 1, 1, 1, SMAX, SMIN, 110);

      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
src/arn_pkg.sv
src/arn_queue.sv
src/arn_front.sv
src/arn_log2.sv
src/arn_div.sv
src/arn_back.sv
src/auto_range_normalizer.sv
src/arn_checker.sv
test/auto_range_normalizer_checker.sv
test/auto_range_normalizer_tb.sv
